### src/rmq_pkg.sv
package rmq_pkg;

  localparam int unsigned ONE_Q14   = 16384;
  localparam int unsigned ROOT_W    = 17;   // floor(sqrt(t << 16)) for t below 2^18
  localparam int unsigned RAD_W     = 34;
  localparam int unsigned SQ_ITERS  = 17;
  localparam int unsigned SQ_STAGES = 9;    // two root bits per stage, one in the last
  localparam int unsigned Q_W       = 16;
  localparam int unsigned DIV_STAGES = 8;   // two quotient bits per stage
  localparam int unsigned N_LANES   = 3;
  localparam int unsigned SQ_FIRST  = 1;
  localparam int unsigned PREP_ST   = SQ_FIRST + SQ_STAGES;
  localparam int unsigned DIV_FIRST = PREP_ST + 1;
  localparam int unsigned N_STAGES  = DIV_FIRST + DIV_STAGES;

  // slot that takes the quarter of the root; other slots use dividers in ascending order
  localparam logic [1:0] SLOT_X = 2'd0;
  localparam logic [1:0] SLOT_Y = 2'd1;
  localparam logic [1:0] SLOT_Z = 2'd2;
  localparam logic [1:0] SLOT_W = 2'd3;

  typedef struct packed {
    logic                           deg;
    logic [1:0]                     qpos;
    logic [RAD_W-1:0]               rad;
    logic [ROOT_W+2:0]              srem;
    logic [ROOT_W-1:0]              root;
    logic [N_LANES-1:0][17:0]       num;
    logic [N_LANES-1:0]             neg;
    logic [N_LANES-1:0]             ovf;
    logic [N_LANES-1:0][ROOT_W:0]   drem;
    logic [N_LANES-1:0][Q_W-1:0]    quo;
    logic [N_LANES-1:0][Q_W-1:0]    nlow;
    logic [14:0]                    quarter;
  } pipe_t;

endpackage

### src/rmq_if.sv
interface rmq_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] e00;
  logic signed [15:0] e01;
  logic signed [15:0] e02;
  logic signed [15:0] e10;
  logic signed [15:0] e11;
  logic signed [15:0] e12;
  logic signed [15:0] e20;
  logic signed [15:0] e21;
  logic signed [15:0] e22;
  logic signed [15:0] e33;

  modport source (output valid, e00, e01, e02, e10, e11, e12, e20, e21, e22, e33,
                  input ready);
  modport sink (input valid, e00, e01, e02, e10, e11, e12, e20, e21, e22, e33,
                output ready);
endinterface

interface rmq_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] qx;
  logic signed [15:0] qy;
  logic signed [15:0] qz;
  logic signed [15:0] qw;
  logic               degenerate;

  modport source (output valid, qx, qy, qz, qw, degenerate, input ready);
  modport sink (input valid, qx, qy, qz, qw, degenerate, output ready);
endinterface

### src/rotation_matrix_to_quaternion_top.sv
// Rotation matrix to quaternion (Shepperd's method), signed Q2.14 in and out.
// Fully pipelined: one matrix accepted per cycle while the output side keeps
// taking results. The pipeline is the input stage, the square root (nine
// stages, two root bits each, one in the last), one divider set-up stage,
// the three parallel restoring dividers (eight stages, two quotient bits
// each) and the output register. A stall on the output holds the whole
// pipeline, so nothing is lost or repeated. A non-positive radicand
// gives zero components with degenerate set; quotients saturate.
module rotation_matrix_to_quaternion_top
  import rmq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  rmq_in_if.sink    in_i,
  rmq_out_if.source out_o
);

  pipe_t              st_q [N_STAGES];
  pipe_t              st_d [N_STAGES];
  logic [N_STAGES-1:0] vld_q;
  logic               en;

  logic               out_vld_q;
  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
  logic               deg_q;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // input stage: branch choice, radicand and the three numerators
  always_comb begin
    logic signed [17:0] a00, a01, a02, a10, a11, a12, a20, a21, a22, a33;
    logic signed [17:0] tr, t;
    logic [1:0]         ii;
    logic               deg;
    st_d[0] = '0;
    a00 = 18'(in_i.e00); a01 = 18'(in_i.e01); a02 = 18'(in_i.e02);
    a10 = 18'(in_i.e10); a11 = 18'(in_i.e11); a12 = 18'(in_i.e12);
    a20 = 18'(in_i.e20); a21 = 18'(in_i.e21); a22 = 18'(in_i.e22);
    a33 = 18'(in_i.e33);
    tr  = a00 + a11 + a22 + a33;
    deg = 1'b0;
    ii  = SLOT_X;
    t   = tr;
    if (tr >= 18'sd16384) begin
      st_d[0].qpos   = SLOT_W;
      st_d[0].num[0] = a12 - a21;
      st_d[0].num[1] = a20 - a02;
      st_d[0].num[2] = a01 - a10;
    end else begin
      ii = SLOT_X;
      if (a00 <= a11) ii = SLOT_Y;
      if (ii == SLOT_X) begin
        if (a22 > a00) ii = SLOT_Z;
      end else begin
        if (a22 > a11) ii = SLOT_Z;
      end
      st_d[0].qpos = ii;
      case (ii)
        SLOT_X: begin
          t = a00 - a11 - a22 + 18'sd16384;
          st_d[0].num[0] = a10 + a01;
          st_d[0].num[1] = a20 + a02;
          st_d[0].num[2] = a12 - a21;
        end
        SLOT_Y: begin
          t = a11 - a22 - a00 + 18'sd16384;
          st_d[0].num[0] = a01 + a10;
          st_d[0].num[1] = a21 + a12;
          st_d[0].num[2] = a20 - a02;
        end
        default: begin
          t = a22 - a00 - a11 + 18'sd16384;
          st_d[0].num[0] = a02 + a20;
          st_d[0].num[1] = a12 + a21;
          st_d[0].num[2] = a01 - a10;
        end
      endcase
      deg = (t <= 18'sd0);
    end
    st_d[0].deg = deg;
    st_d[0].rad = deg ? '0 : {t, 16'h0000};
  end

  // square root, two result bits per stage, one in the last stage
  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
    always_comb begin
      logic [ROOT_W+2:0] rem;
      logic [ROOT_W+2:0] trial;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0]  rad;
      st_d[SQ_FIRST+g] = st_q[SQ_FIRST+g-1];
      rem   = st_q[SQ_FIRST+g-1].srem;
      root  = st_q[SQ_FIRST+g-1].root;
      rad   = st_q[SQ_FIRST+g-1].rad;
      trial = '0;
      for (int k = 0; k < 2; k++) begin
        if (2 * g + k < SQ_ITERS) begin
          rem   = {rem[ROOT_W:0], rad[RAD_W-1 -: 2]};
          rad   = {rad[RAD_W-3:0], 2'b00};
          trial = {1'b0, root, 2'b01};
          if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[ROOT_W-2:0], 1'b1};
          end else begin
            root = {root[ROOT_W-2:0], 1'b0};
          end
        end
      end
      st_d[SQ_FIRST+g].srem = rem;
      st_d[SQ_FIRST+g].root = root;
      st_d[SQ_FIRST+g].rad  = rad;
    end
  end

  // divider set-up: magnitude, rounding bias and range check
  always_comb begin
    logic [ROOT_W-1:0]  f;
    logic signed [17:0] dv;
    logic [16:0]        mag;
    logic [31:0]        nm;
    logic [ROOT_W:0]    fq;
    st_d[PREP_ST] = st_q[PREP_ST-1];
    f  = st_q[PREP_ST-1].root;
    fq = {1'b0, f} + 18'd2;
    st_d[PREP_ST].quarter = fq[16:2];
    for (int l = 0; l < N_LANES; l++) begin
      dv  = $signed(st_q[PREP_ST-1].num[l]);
      mag = (dv < 0) ? 17'(-dv) : 17'(dv);
      nm  = {1'b0, mag, 14'h0000} + 32'(f >> 1);
      st_d[PREP_ST].neg[l]  = (dv < 0);
      st_d[PREP_ST].ovf[l]  = ({1'b0, nm} >= {f, 16'h0000});
      st_d[PREP_ST].drem[l] = {2'b00, nm[31:16]};
      st_d[PREP_ST].nlow[l] = nm[15:0];
      st_d[PREP_ST].quo[l]  = '0;
    end
  end

  // restoring division, two quotient bits per stage in each lane
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    always_comb begin
      logic [ROOT_W:0] rem;
      logic [Q_W-1:0]  nl;
      logic [Q_W-1:0]  qq;
      logic [ROOT_W:0] fz;
      st_d[DIV_FIRST+g] = st_q[DIV_FIRST+g-1];
      fz = {1'b0, st_q[DIV_FIRST+g-1].root};
      for (int l = 0; l < N_LANES; l++) begin
        rem = st_q[DIV_FIRST+g-1].drem[l];
        nl  = st_q[DIV_FIRST+g-1].nlow[l];
        qq  = st_q[DIV_FIRST+g-1].quo[l];
        for (int k = 0; k < 2; k++) begin
          rem = {rem[ROOT_W-1:0], nl[Q_W-1]};
          nl  = {nl[Q_W-2:0], 1'b0};
          if (rem >= fz) begin
            rem = rem - fz;
            qq  = {qq[Q_W-2:0], 1'b1};
          end else begin
            qq  = {qq[Q_W-2:0], 1'b0};
          end
        end
        st_d[DIV_FIRST+g].drem[l] = rem;
        st_d[DIV_FIRST+g].nlow[l] = nl;
        st_d[DIV_FIRST+g].quo[l]  = qq;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[N_STAGES-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < N_STAGES; s++) st_q[s] <= st_d[s];
    end
  end

  // saturation and mapping of divider lanes onto quaternion slots
  logic signed [15:0] slot_d [4];

  always_comb begin
    pipe_t      p;
    logic [1:0] ln;
    logic       big;
    p = st_q[N_STAGES-1];
    for (int s = 0; s < 4; s++) begin
      ln  = (2'(s) > p.qpos) ? 2'(s - 1) : 2'(s);
      big = 1'b0;
      slot_d[s] = '0;
      if (p.deg) begin
        slot_d[s] = '0;
      end else if (2'(s) == p.qpos) begin
        slot_d[s] = {1'b0, p.quarter};
      end else begin
        big = p.ovf[ln] || p.quo[ln][Q_W-1];
        if (p.neg[ln]) slot_d[s] = big ? 16'sh8000 : -$signed(p.quo[ln]);
        else           slot_d[s] = big ? 16'sh7fff : $signed(p.quo[ln]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[N_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q  <= slot_d[SLOT_X];
      qy_q  <= slot_d[SLOT_Y];
      qz_q  <= slot_d[SLOT_Z];
      qw_q  <= slot_d[SLOT_W];
      deg_q <= st_q[N_STAGES-1].deg;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.qx         = qx_q;
  assign out_o.qy         = qy_q;
  assign out_o.qz         = qz_q;
  assign out_o.qw         = qw_q;
  assign out_o.degenerate = deg_q;

endmodule
